FILE: rtl/foc_ct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_ct_pkg
// Shared types, fixed-point constants and helper functions for the FOC
// Clarke/Park coordinate transform.
// ----------------------------------------------------------------------------
package foc_ct_pkg;

    // Default depth of the full-wave sine table
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Fixed-point format
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = 34;

    // Q1.15 constants
    localparam logic signed [15:0] K_INV_SQRT3  = 16'sd18919;
    localparam logic signed [15:0] K_SQRT3_HALF = 16'sd28378;
    localparam logic signed [15:0] K_MINUS_HALF = -16'sd16384;
    localparam logic signed [15:0] HALF_Q15     = 16'sd16384;
    localparam int                 Q15_MAX      = 32767;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] SAT_MAX    = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_MIN    = -PROD_W'(32768);

    localparam real TWO_PI = 6.283185307179586;

    // Command codes
    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    // Input beat
    typedef struct packed {
        logic               command;
        logic signed [15:0] phase_a_in;
        logic signed [15:0] phase_b_in;
        logic signed [15:0] phase_c_in;
        logic signed [15:0] direct_in;
        logic signed [15:0] quad_in;
        logic        [15:0] angle;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [15:0] sine_out;
        logic signed [15:0] cosine_out;
        logic signed [15:0] alpha_out;
        logic signed [15:0] beta_out;
        logic signed [15:0] direct_out;
        logic signed [15:0] quad_out;
        logic signed [15:0] phase_a_out;
        logic signed [15:0] phase_b_out;
        logic signed [15:0] phase_c_out;
        logic               saturated;
    } out_beat_t;

    // Rounded and clipped value with its clip flag
    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } sat_t;

    // Round half up, drop the fraction bits, clip to 16 bits
    function automatic sat_t round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        sat_t                     res;
        r = (p + ROUND_HALF) >>> FRAC_BITS;
        if (r > SAT_MAX) begin
            res.value = 16'sh7FFF;
            res.clip  = 1'b1;
        end else if (r < SAT_MIN) begin
            res.value = 16'sh8000;
            res.clip  = 1'b1;
        end else begin
            res.value = r[15:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

    // Sine table entry n: round(32767*sin), halves away from zero.
    // Sine of exactly one half is pinned, since it lands on a rounding tie.
    function automatic logic signed [15:0] sine_value(
        input int  n,
        input int  depth,
        input real step
    );
        int                 twelve_n;
        logic signed [15:0] res;
        twelve_n = 12 * n;
        if (twelve_n == depth || twelve_n == 5 * depth) begin
            res = HALF_Q15;
        end else if (twelve_n == 7 * depth || twelve_n == 11 * depth) begin
            res = -HALF_Q15;
        end else begin
            res = 16'(int'(real'(Q15_MAX) * $sin(real'(n) * step)));
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/foc_coordinate_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_coordinate_transform
// Fixed-point Clarke/Park transform (abc to dq) and its inverse (dq to abc).
// ----------------------------------------------------------------------------
// Six-stage pipeline that takes one beat per clock while the output beat is not
// stalled. A result is presented on m_valid from the output register.
// Stage one forms the table indexes and phase difference. Stage two reads sine
// and cosine from a ROM of SINE_TABLE_DEPTH entries (two read ports, registered
// data) and forms the Clarke beta product. Stage three rounds Clarke beta and
// forms the inverse Park products. Stage four picks alpha and beta for the
// mode. Stage five runs the Park or inverse Clarke products, and stage six is
// the output register. All stages move together; they hold only while the
// output beat waits, so s_ready follows m_ready whenever a result is pending.
// ----------------------------------------------------------------------------
module foc_coordinate_transform #(
    parameter int SINE_TABLE_DEPTH = foc_ct_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire foc_ct_pkg::in_beat_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output foc_ct_pkg::out_beat_t m_data
);

    localparam int IW     = $clog2(SINE_TABLE_DEPTH);
    localparam int AW     = 16 + IW + 1;
    localparam int PW     = foc_ct_pkg::PROD_W;
    localparam int STAGES = 6;
    localparam real ANGLE_STEP = foc_ct_pkg::TWO_PI / SINE_TABLE_DEPTH;

    typedef logic [IW-1:0]        idx_t;
    typedef logic [IW:0]          idx_ext_t;
    typedef logic signed [PW-1:0] prod_t;

    localparam idx_ext_t DEPTH_EXT   = idx_ext_t'(SINE_TABLE_DEPTH);
    localparam idx_ext_t QUARTER_EXT = idx_ext_t'(SINE_TABLE_DEPTH / 4);

    typedef struct packed {
        logic               inv;
        logic signed [15:0] phase_a;
        logic signed [15:0] direct;
        logic signed [15:0] quad;
        idx_t               sin_idx;
        idx_t               cos_idx;
        logic signed [16:0] diff;
    } st1_t;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] phase_a;
        logic signed [15:0] direct;
        logic signed [15:0] quad;
        prod_t              beta_prod;
    } st2_t;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] sine;
        logic signed [15:0] cosine;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic               flag;
        prod_t              p0;
        prod_t              p1;
        prod_t              p2;
        prod_t              p3;
    } st3_t;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] sine;
        logic signed [15:0] cosine;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic               flag;
    } st4_t;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] sine;
        logic signed [15:0] cosine;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic               flag;
        prod_t              m0;
        prod_t              m1;
        prod_t              m2;
        prod_t              m3;
    } st5_t;

    // Sine ROM, built at elaboration
    logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        assign sine_rom[gi] = foc_ct_pkg::sine_value(gi, SINE_TABLE_DEPTH, ANGLE_STEP);
    end

    logic [STAGES-1:0]     valid_reg;
    logic                  pipe_en;
    st1_t                  s1_reg, s1_next;
    st2_t                  s2_reg, s2_next;
    logic signed [15:0]    sine_rd_reg, cosine_rd_reg;
    st3_t                  s3_reg, s3_next;
    st4_t                  s4_reg, s4_next;
    st5_t                  s5_reg, s5_next;
    foc_ct_pkg::out_beat_t out_reg, out_next;
    logic                  out_inv_reg;

    // Advance every stage unless the output beat is stalled
    assign pipe_en = !valid_reg[STAGES-1] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = valid_reg[STAGES-1];
    assign m_data  = out_reg;

    // Stage 1: table indexes and phase difference
    always_comb begin
        logic [AW-1:0] angle_prod;
        idx_ext_t      cos_sum;
        angle_prod = AW'(s_data.angle) * AW'(SINE_TABLE_DEPTH);
        s1_next.sin_idx = angle_prod[16 +: IW];
        cos_sum = idx_ext_t'(s1_next.sin_idx) + QUARTER_EXT;
        if (cos_sum >= DEPTH_EXT) begin
            s1_next.cos_idx = idx_t'(cos_sum - DEPTH_EXT);
        end else begin
            s1_next.cos_idx = idx_t'(cos_sum);
        end
        s1_next.inv     = (s_data.command == foc_ct_pkg::CMD_INVERSE);
        s1_next.phase_a = s_data.phase_a_in;
        s1_next.direct  = s_data.direct_in;
        s1_next.quad    = s_data.quad_in;
        s1_next.diff    = 17'(s_data.phase_b_in) - 17'(s_data.phase_c_in);
    end

    // Stage 2: Clarke beta product (ROM read sits in the register block)
    always_comb begin
        s2_next.inv       = s1_reg.inv;
        s2_next.phase_a   = s1_reg.phase_a;
        s2_next.direct    = s1_reg.direct;
        s2_next.quad      = s1_reg.quad;
        s2_next.beta_prod = PW'(foc_ct_pkg::K_INV_SQRT3) * PW'(s1_reg.diff);
    end

    // Stage 3: finish Clarke beta, form inverse Park products
    always_comb begin
        foc_ct_pkg::sat_t bsat;
        bsat = foc_ct_pkg::round_sat(s2_reg.beta_prod);
        s3_next.inv    = s2_reg.inv;
        s3_next.sine   = sine_rd_reg;
        s3_next.cosine = cosine_rd_reg;
        s3_next.alpha  = s2_reg.phase_a;
        s3_next.beta   = bsat.value;
        s3_next.flag   = bsat.clip && !s2_reg.inv;
        s3_next.p0     = PW'(cosine_rd_reg) * PW'(s2_reg.direct);
        s3_next.p1     = PW'(sine_rd_reg) * PW'(s2_reg.quad);
        s3_next.p2     = PW'(sine_rd_reg) * PW'(s2_reg.direct);
        s3_next.p3     = PW'(cosine_rd_reg) * PW'(s2_reg.quad);
    end

    // Stage 4: pick alpha and beta for the mode
    always_comb begin
        foc_ct_pkg::sat_t ra;
        foc_ct_pkg::sat_t rb;
        ra = foc_ct_pkg::round_sat(s3_reg.p0 - s3_reg.p1);
        rb = foc_ct_pkg::round_sat(s3_reg.p2 + s3_reg.p3);
        s4_next.inv    = s3_reg.inv;
        s4_next.sine   = s3_reg.sine;
        s4_next.cosine = s3_reg.cosine;
        if (s3_reg.inv) begin
            s4_next.alpha = ra.value;
            s4_next.beta  = rb.value;
            s4_next.flag  = ra.clip || rb.clip;
        end else begin
            s4_next.alpha = s3_reg.alpha;
            s4_next.beta  = s3_reg.beta;
            s4_next.flag  = s3_reg.flag;
        end
    end

    // Stage 5: Park or inverse Clarke products on shared multipliers
    always_comb begin
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        x0 = s4_reg.inv ? foc_ct_pkg::K_MINUS_HALF : s4_reg.cosine;
        x1 = s4_reg.inv ? foc_ct_pkg::K_SQRT3_HALF : s4_reg.sine;
        s5_next.inv    = s4_reg.inv;
        s5_next.sine   = s4_reg.sine;
        s5_next.cosine = s4_reg.cosine;
        s5_next.alpha  = s4_reg.alpha;
        s5_next.beta   = s4_reg.beta;
        s5_next.flag   = s4_reg.flag;
        s5_next.m0     = PW'(x0) * PW'(s4_reg.alpha);
        s5_next.m1     = PW'(x1) * PW'(s4_reg.beta);
        s5_next.m2     = PW'(s4_reg.cosine) * PW'(s4_reg.beta);
        s5_next.m3     = PW'(s4_reg.sine) * PW'(s4_reg.alpha);
    end

    // Stage 6: round, clip and zero the fields the mode leaves unused
    always_comb begin
        foc_ct_pkg::sat_t r_sum;
        foc_ct_pkg::sat_t r_diff;
        foc_ct_pkg::sat_t r_quad;
        r_sum  = foc_ct_pkg::round_sat(s5_reg.m0 + s5_reg.m1);
        r_diff = foc_ct_pkg::round_sat(s5_reg.m0 - s5_reg.m1);
        r_quad = foc_ct_pkg::round_sat(s5_reg.m2 - s5_reg.m3);
        out_next.sine_out   = s5_reg.sine;
        out_next.cosine_out = s5_reg.cosine;
        out_next.alpha_out  = s5_reg.alpha;
        out_next.beta_out   = s5_reg.beta;
        if (s5_reg.inv) begin
            out_next.direct_out  = '0;
            out_next.quad_out    = '0;
            out_next.phase_a_out = s5_reg.alpha;
            out_next.phase_b_out = r_sum.value;
            out_next.phase_c_out = r_diff.value;
            out_next.saturated   = s5_reg.flag || r_sum.clip || r_diff.clip;
        end else begin
            out_next.direct_out  = r_sum.value;
            out_next.quad_out    = r_quad.value;
            out_next.phase_a_out = '0;
            out_next.phase_b_out = '0;
            out_next.phase_c_out = '0;
            out_next.saturated   = s5_reg.flag || r_sum.clip || r_quad.clip;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[STAGES-2:0], s_valid};
        end
    end

    // Datapath registers and ROM reads; hold on stall
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            sine_rd_reg   <= sine_rom[s1_reg.sin_idx];
            cosine_rd_reg <= sine_rom[s1_reg.cos_idx];
            s3_reg        <= s3_next;
            s4_reg        <= s4_next;
            s5_reg        <= s5_next;
            out_reg       <= out_next;
            out_inv_reg   <= s5_reg.inv;
        end
    end

    // Accepted beat lands in stage one
    a_accept_fills_stage1 : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted beat did not enter stage one");

    // Inverse results carry alpha as phase a and zero dq
    a_inverse_fields : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_inv_reg |->
            m_data.phase_a_out == m_data.alpha_out &&
            m_data.direct_out == 16'sd0 && m_data.quad_out == 16'sd0)
        else $error("inverse result fields inconsistent");

    // Forward results leave the phase outputs at zero
    a_forward_fields : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !out_inv_reg |->
            m_data.phase_a_out == 16'sd0 && m_data.phase_b_out == 16'sd0 &&
            m_data.phase_c_out == 16'sd0)
        else $error("forward result drives phase outputs");

    // Table values never reach the negative full-scale code
    a_table_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sine_out != 16'sh8000 && m_data.cosine_out != 16'sh8000)
        else $error("table value out of range");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - FOC coordinate transform testbench
// Drives abc/dq sample beats into the transform under random source gaps
// and sink stalls, predicts every result beat with a local fixed-point
// model (own sine table, Q1.15 rounding and clipping), and compares each
// result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    localparam int     LUT_DEPTH      = foc_ct_pkg::SINE_TABLE_DEPTH_DEF;
    localparam int     RANDOM_BEATS   = 1300;
    localparam int     DRAIN_CYCLES   = 16;
    localparam longint INV_SQRT3_Q15  = 18919;
    localparam longint SQRT3_HALF_Q15 = 28378;
    localparam longint MINUS_HALF_Q15 = -16384;
    localparam real    HALF_PI        = 1.5707963267948966;

    // Rounded Q1.15 value with its clip flag
    typedef struct packed {
        logic               clip;
        logic signed [15:0] value;
    } q15_clip_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    foc_ct_pkg::in_beat_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    foc_ct_pkg::out_beat_t m_data;

    int                    sine_lut [LUT_DEPTH];
    foc_ct_pkg::out_beat_t expected_frames [$];
    foc_ct_pkg::out_beat_t want_frame;
    int                    mismatch_count = 0;
    int                    burst_left     = 0;

    foc_coordinate_transform dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Build the sine table: fold into the first quadrant, round halves away
    // from zero, pin the exact one-half point
    initial begin
        int  t;
        int  mag;
        bit  neg;
        for (int n = 0; n < LUT_DEPTH; n++) begin
            t   = 4 * n;
            neg = 1'b0;
            if (t >= 2 * LUT_DEPTH) begin
                t   = t - 2 * LUT_DEPTH;
                neg = 1'b1;
            end
            if (t > LUT_DEPTH) begin
                t = 2 * LUT_DEPTH - t;
            end
            if (3 * t == LUT_DEPTH) begin
                mag = 16384;
            end else begin
                mag = $rtoi(32767.0 * $sin(real'(t) * HALF_PI / real'(LUT_DEPTH)) + 0.5);
                if (mag > 32767) begin
                    mag = 32767;
                end
            end
            sine_lut[n] = neg ? -mag : mag;
        end
    end

    // Round half up, drop 15 fraction bits, clip to 16 bits
    function automatic q15_clip_t round_clip(input longint p);
        longint    r;
        q15_clip_t res;
        r = (p + 64'sd16384) >>> 15;
        if (r > 32767) begin
            res = {1'b1, 16'sh7FFF};
        end else if (r < -32768) begin
            res = {1'b1, 16'sh8000};
        end else begin
            res = {1'b0, 16'(r)};
        end
        return res;
    endfunction

    // Expected result beat for one sample beat
    function automatic foc_ct_pkg::out_beat_t transform_predict(
        input foc_ct_pkg::in_beat_t item
    );
        int                    sin_idx;
        int                    cos_idx;
        longint                sn, cs, al, be, x, y;
        q15_clip_t             beta, alpha, r0, r1;
        foc_ct_pkg::out_beat_t res;
        sin_idx = (int'(item.angle) * LUT_DEPTH) >> 16;
        cos_idx = (sin_idx + LUT_DEPTH / 4) % LUT_DEPTH;
        sn      = sine_lut[sin_idx];
        cs      = sine_lut[cos_idx];
        res            = '0;
        res.sine_out   = 16'(sn);
        res.cosine_out = 16'(cs);
        if (item.command == foc_ct_pkg::CMD_FORWARD) begin
            // Clarke, then Park on the clipped alpha/beta
            al   = item.phase_a_in;
            x    = item.phase_b_in;
            y    = item.phase_c_in;
            beta = round_clip(INV_SQRT3_Q15 * (x - y));
            be   = beta.value;
            r0   = round_clip(cs * al + sn * be);
            r1   = round_clip(cs * be - sn * al);
            res.alpha_out  = 16'(al);
            res.beta_out   = beta.value;
            res.direct_out = r0.value;
            res.quad_out   = r1.value;
            res.saturated  = beta.clip | r0.clip | r1.clip;
        end else begin
            // Inverse Park, then inverse Clarke on the clipped alpha/beta
            x     = item.direct_in;
            y     = item.quad_in;
            alpha = round_clip(cs * x - sn * y);
            beta  = round_clip(sn * x + cs * y);
            al    = alpha.value;
            be    = beta.value;
            r0    = round_clip(MINUS_HALF_Q15 * al + SQRT3_HALF_Q15 * be);
            r1    = round_clip(MINUS_HALF_Q15 * al - SQRT3_HALF_Q15 * be);
            res.alpha_out   = alpha.value;
            res.beta_out    = beta.value;
            res.phase_a_out = alpha.value;
            res.phase_b_out = r0.value;
            res.phase_c_out = r1.value;
            res.saturated   = alpha.clip | beta.clip | r0.clip | r1.clip;
        end
        return res;
    endfunction

    // Source gap: mostly none or short, a few long, with gapless bursts
    function automatic int source_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end else if (pick < 50) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Random Q1.15 value, biased toward the rails
    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one sample beat and record its expected result on acceptance
    task automatic push_sample(input foc_ct_pkg::in_beat_t item);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_frames.push_back(transform_predict(item));
    endtask

    task automatic push_abc(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic signed [15:0] c, input logic [15:0] ang);
        foc_ct_pkg::in_beat_t item;
        item            = '0;
        item.command    = foc_ct_pkg::CMD_FORWARD;
        item.phase_a_in = a;
        item.phase_b_in = b;
        item.phase_c_in = c;
        item.direct_in  = 16'($urandom);
        item.quad_in    = 16'($urandom);
        item.angle      = ang;
        push_sample(item);
    endtask

    task automatic push_dq(input logic signed [15:0] d, input logic signed [15:0] q,
                           input logic [15:0] ang);
        foc_ct_pkg::in_beat_t item;
        item            = '0;
        item.command    = foc_ct_pkg::CMD_INVERSE;
        item.phase_a_in = 16'($urandom);
        item.phase_b_in = 16'($urandom);
        item.phase_c_in = 16'($urandom);
        item.direct_in  = d;
        item.quad_in    = q;
        item.angle      = ang;
        push_sample(item);
    endtask

    // Rail values in both directions, including clipped beta and phase outputs
    task automatic test_rail_values();
        push_abc(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'h0000);
        push_abc(16'sh8000, 16'sh8000, 16'sh7FFF, 16'h0000);
        push_abc(16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
        push_abc(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h2000);
        push_abc(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'h6000);
        push_abc(16'shFFFF, 16'sh0001, 16'shFFFF, 16'hFFFF);
        push_dq(16'sh7FFF, 16'sh7FFF, 16'h2000);
        push_dq(16'sh8000, 16'sh8000, 16'h2000);
        push_dq(16'sh8000, 16'sh7FFF, 16'hA000);
        push_dq(16'sh7FFF, 16'sh8000, 16'h0000);
        push_dq(16'sh8000, 16'sh0000, 16'h0000);
        push_dq(16'sh0000, 16'sh8000, 16'h4000);
    endtask

    // Quadrant boundaries, table wrap and the angle extremes
    task automatic test_table_angles();
        push_abc(16'sh7FFF, 16'shC000, 16'shC001, 16'h0000);
        push_dq(16'sh4000, 16'shC000, 16'h3FFF);
        push_abc(16'sh7FFF, 16'shC000, 16'shC001, 16'h4000);
        push_dq(16'sh4000, 16'shC000, 16'h8000);
        push_abc(16'sh7FFF, 16'shC000, 16'shC001, 16'hC000);
        push_dq(16'sh4000, 16'shC000, 16'hFFFF);
        push_abc(16'sh2000, 16'sh1000, 16'shD000, 16'h0040);
        push_dq(16'sh2000, 16'sh1000, 16'h003F);
        push_abc(16'sh2000, 16'sh1000, 16'shD000, 16'h5555);
        push_dq(16'sh2000, 16'sh1000, 16'h2AAA);
    endtask

    // Mixed random traffic: balanced three-phase sets, rails and noise
    task automatic test_random_traffic();
        foc_ct_pkg::in_beat_t item;
        int                   a, b;
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            item         = '0;
            item.command = $urandom_range(0, 1) ? foc_ct_pkg::CMD_INVERSE
                                                : foc_ct_pkg::CMD_FORWARD;
            item.phase_a_in = rand_q15();
            item.phase_b_in = rand_q15();
            item.phase_c_in = rand_q15();
            item.direct_in  = rand_q15();
            item.quad_in    = rand_q15();
            if (item.command == foc_ct_pkg::CMD_FORWARD && $urandom_range(0, 2) == 0) begin
                a = $urandom_range(0, 32766) - 16383;
                b = $urandom_range(0, 32766) - 16383;
                item.phase_a_in = 16'(a);
                item.phase_b_in = 16'(b);
                item.phase_c_in = 16'(-(a + b));
            end
            if ($urandom_range(0, 7) == 0) begin
                item.angle = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 128) - 64);
            end else begin
                item.angle = 16'($urandom);
            end
            push_sample(item);
        end
    endtask

    // Sink stalls: short bursts mostly, a few long stalls and stall-free runs
    initial begin
        int run, stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 8);
            stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    task automatic compare_field(input string name, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                want_frame = expected_frames.pop_front();
                compare_field("sine_out", want_frame.sine_out, m_data.sine_out);
                compare_field("cosine_out", want_frame.cosine_out, m_data.cosine_out);
                compare_field("alpha_out", want_frame.alpha_out, m_data.alpha_out);
                compare_field("beta_out", want_frame.beta_out, m_data.beta_out);
                compare_field("direct_out", want_frame.direct_out, m_data.direct_out);
                compare_field("quad_out", want_frame.quad_out, m_data.quad_out);
                compare_field("phase_a_out", want_frame.phase_a_out, m_data.phase_a_out);
                compare_field("phase_b_out", want_frame.phase_b_out, m_data.phase_b_out);
                compare_field("phase_c_out", want_frame.phase_c_out, m_data.phase_c_out);
                compare_field("saturated", {15'd0, want_frame.saturated},
                              {15'd0, m_data.saturated});
            end
        end
    end

    // Reset, run the tests in turn, drain and report
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rail_values();
        test_table_angles();
        test_random_traffic();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: foc_coordinate_transform.f
rtl/foc_ct_pkg.sv
rtl/foc_coordinate_transform.sv
tb/tb.sv
